// ----- rtl/core/gmdfs_pkg.sv -----
// ----------------------------------------------------------------------------
// gmdfs_pkg: shared types and constants of the grid maze path finder
// Field widths, register indexes, search directions and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package gmdfs_pkg;

  localparam int MAX_ROWS_DEF = 8;
  localparam int MAX_COLS_DEF = 8;

  localparam int POS_W      = 3;  // row or column of a cell
  localparam int DIM_W      = 4;  // rows or columns in use
  localparam int DEPTH_W    = 7;  // reported depth
  localparam int DIR_W      = 3;  // next direction, 0..4
  localparam int TOT_W      = 2 * DIM_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_ROW = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_COL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GOAL_ROW  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_GOAL_COL  = 3'd5;

  // register reset values
  localparam logic [DIM_W-1:0] RST_GRID_ROWS = 4'd8;
  localparam logic [DIM_W-1:0] RST_GRID_COLS = 4'd8;
  localparam logic [POS_W-1:0] RST_START_ROW = 3'd0;
  localparam logic [POS_W-1:0] RST_START_COL = 3'd0;
  localparam logic [POS_W-1:0] RST_GOAL_ROW  = 3'd7;
  localparam logic [POS_W-1:0] RST_GOAL_COL  = 3'd7;

  // search directions in trial order
  localparam logic [DIR_W-1:0] DIR_WEST  = 3'd0;
  localparam logic [DIR_W-1:0] DIR_NORTH = 3'd1;
  localparam logic [DIR_W-1:0] DIR_EAST  = 3'd2;
  localparam logic [DIR_W-1:0] DIR_SOUTH = 3'd3;
  localparam logic [DIR_W-1:0] DIR_DONE  = 3'd4;

  // bit positions in a wall entry
  localparam int WALL_EAST  = 0;
  localparam int WALL_SOUTH = 1;

  typedef struct packed {
    logic [1:0]       dir;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
  } gmdfs_entry_t;

  typedef struct packed {
    logic load_wall;
    logic finish;
    logic init;
    logic check;
    logic pop;
    logic resume;
    logic push;
    logic next_dir;
    logic out_rd;
    logic out_stk;
    logic out_load;
    logic out_next;
  } gmdfs_cmd_t;

  typedef struct packed {
    logic total_zero;
    logic bounds_ok;
    logic start_goal;
    logic dir_done;
    logic sp_one;
    logic open;
    logic nb_goal;
    logic out_last;
    logic out_taken;
  } gmdfs_stat_t;

endpackage

// ----- rtl/core/gmdfs_if.sv -----
// ----------------------------------------------------------------------------
// gmdfs_if: stream interfaces of the grid maze path finder
// Cell load channel and cell report channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface gmdfs_in_if;
  logic valid;
  logic ready;
  logic east_wall;
  logic south_wall;
  logic last_cell;

  modport source (output valid, output east_wall, output south_wall,
                  output last_cell, input ready);
  modport sink   (input valid, input east_wall, input south_wall,
                  input last_cell, output ready);
endinterface

interface gmdfs_out_if;
  logic                              valid;
  logic                              ready;
  logic [gmdfs_pkg::POS_W-1:0]       cell_row;
  logic [gmdfs_pkg::POS_W-1:0]       cell_col;
  logic                              visited;
  logic [gmdfs_pkg::DEPTH_W-1:0]     depth;
  logic                              on_path;
  logic                              last_result;

  modport source (output valid, output cell_row, output cell_col, output visited,
                  output depth, output on_path, output last_result, input ready);
  modport sink   (input valid, input cell_row, input cell_col, input visited,
                  input depth, input on_path, input last_result, output ready);
endinterface

// ----- rtl/core/gmdfs_ctrl.sv -----
// ----------------------------------------------------------------------------
// gmdfs_ctrl: sequencer of the grid maze path finder
// Steps through loading, the depth-first search and the cell reports.
// ----------------------------------------------------------------------------
module gmdfs_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_last,
  output logic                   in_ready,
  input  gmdfs_pkg::gmdfs_stat_t stat,
  output gmdfs_pkg::gmdfs_cmd_t  cmd
);

  typedef enum logic [8:0] {
    S_LOAD     = 9'b000000001,
    S_INIT     = 9'b000000010,
    S_CHECK    = 9'b000000100,
    S_MOVE     = 9'b000001000,
    S_POP      = 9'b000010000,
    S_OUT_RD   = 9'b000100000,
    S_OUT_STK  = 9'b001000000,
    S_OUT_CMP  = 9'b010000000,
    S_OUT_WAIT = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_wall = 1'b1;
          if (in_last) begin
            if (stat.total_zero) begin
              cmd.finish = 1'b1;
            end else begin
              state_nxt = S_INIT;
            end
          end
        end
      end
      S_INIT: begin
        cmd.init = 1'b1;
        if (!stat.bounds_ok || stat.start_goal) begin
          state_nxt = S_OUT_RD;
        end else begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.dir_done) begin
          if (stat.sp_one) begin
            state_nxt = S_OUT_RD;
          end else begin
            cmd.pop   = 1'b1;
            state_nxt = S_POP;
          end
        end else begin
          cmd.check = 1'b1;
          state_nxt = S_MOVE;
        end
      end
      S_POP: begin
        cmd.resume = 1'b1;
        state_nxt  = S_CHECK;
      end
      S_MOVE: begin
        if (stat.open) begin
          cmd.push  = 1'b1;
          state_nxt = stat.nb_goal ? S_OUT_RD : S_CHECK;
        end else begin
          cmd.next_dir = 1'b1;
          state_nxt    = S_CHECK;
        end
      end
      S_OUT_RD: begin
        cmd.out_rd = 1'b1;
        state_nxt  = S_OUT_STK;
      end
      S_OUT_STK: begin
        cmd.out_stk = 1'b1;
        state_nxt   = S_OUT_CMP;
      end
      S_OUT_CMP: begin
        cmd.out_load = 1'b1;
        state_nxt    = S_OUT_WAIT;
      end
      S_OUT_WAIT: begin
        if (stat.out_taken) begin
          if (stat.out_last) begin
            cmd.finish = 1'b1;
            state_nxt  = S_LOAD;
          end else begin
            cmd.out_next = 1'b1;
            state_nxt    = S_OUT_RD;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

endmodule

// ----- rtl/core/gmdfs_dp.sv -----
// ----------------------------------------------------------------------------
// gmdfs_dp: datapath of the grid maze path finder
// Configuration registers, wall, depth and stack memories, visit bits, the
// neighbour check and the cell report register.
// ----------------------------------------------------------------------------
module gmdfs_dp #(
  parameter int MAX_ROWS = gmdfs_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = gmdfs_pkg::MAX_COLS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [gmdfs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gmdfs_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                 east_wall,
  input  logic                                 south_wall,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output logic [gmdfs_pkg::POS_W-1:0]          out_row,
  output logic [gmdfs_pkg::POS_W-1:0]          out_col,
  output logic                                 out_visited,
  output logic [gmdfs_pkg::DEPTH_W-1:0]        out_depth,
  output logic                                 out_on_path,
  output logic                                 out_last,
  input  gmdfs_pkg::gmdfs_cmd_t                cmd,
  output gmdfs_pkg::gmdfs_stat_t               stat
);

  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int SP_W  = $clog2(CELLS + 1);
  localparam int POS_W = gmdfs_pkg::POS_W;
  localparam int DIM_W = gmdfs_pkg::DIM_W;
  localparam int DW    = gmdfs_pkg::DEPTH_W;
  localparam int DIR_W = gmdfs_pkg::DIR_W;
  localparam int TOT_W = gmdfs_pkg::TOT_W;

  function automatic logic [AW-1:0] cell_addr(input logic [POS_W-1:0] r,
                                              input logic [POS_W-1:0] c);
    cell_addr = AW'(int'(r) * MAX_COLS + int'(c));
  endfunction

  // configuration
  logic [DIM_W-1:0] rows_r, cols_r;
  logic [POS_W-1:0] start_row_r, start_col_r, goal_row_r, goal_col_r;

  // load bookkeeping
  logic [SP_W-1:0]  lc_r;
  logic [DIM_W-1:0] ld_row_r;
  logic [POS_W-1:0] ld_col_r;

  // search state
  logic [SP_W-1:0]  sp_r;
  logic             found_r;
  logic [CELLS-1:0] visited_r;
  logic [DIR_W-1:0] dir_r;
  logic [POS_W-1:0] cur_row_r, cur_col_r, nb_row_r, nb_col_r;
  logic             edge_ok_r, loaded_r;

  // memories and their read registers
  logic [1:0]              wall_mem  [CELLS];
  logic [DW-1:0]           depth_mem [CELLS];
  gmdfs_pkg::gmdfs_entry_t stack_mem [CELLS];
  logic [1:0]              wall_q_r;
  logic [DW-1:0]           depth_q_r;
  logic                    vis_q_r;
  gmdfs_pkg::gmdfs_entry_t stk_q_r;

  // report
  logic [POS_W-1:0] orow_r, ocol_r;
  logic             res_valid_r;
  logic [POS_W-1:0] res_row_r, res_col_r;
  logic             res_vis_r, res_path_r, res_last_r;
  logic [DW-1:0]    res_depth_r;

  logic [DIM_W-1:0] used_rows, used_cols;
  logic [TOT_W-1:0] total;
  logic             load_ok, ld_wrap, out_wrap;
  logic [AW-1:0]    ld_addr, start_addr, nb_addr, wall_addr, out_addr, stk_raddr;
  logic [SP_W-1:0]  sp_m1, sp_m2;
  logic             chk_edge, chk_loaded, wall_bit, on_path, is_last;
  logic [POS_W-1:0] w_row, w_col, n_row, n_col;
  logic             dp_we;
  logic [AW-1:0]    dp_waddr;
  logic [DW-1:0]    dp_wdata, sp_depth;
  gmdfs_pkg::gmdfs_entry_t push_entry;

  assign used_rows = (rows_r > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : rows_r;
  assign used_cols = (cols_r > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : cols_r;
  assign total     = TOT_W'(used_rows) * TOT_W'(used_cols);
  assign load_ok   = TOT_W'(lc_r) < total;
  assign ld_wrap   = (DIM_W'(ld_col_r) + DIM_W'(1)) >= used_cols;
  assign out_wrap  = (DIM_W'(ocol_r) + DIM_W'(1)) >= used_cols;
  assign is_last   = ((DIM_W'(orow_r) + DIM_W'(1)) == used_rows) &&
                     ((DIM_W'(ocol_r) + DIM_W'(1)) == used_cols);

  assign ld_addr    = cell_addr(ld_row_r[POS_W-1:0], ld_col_r);
  assign start_addr = cell_addr(start_row_r, start_col_r);
  assign nb_addr    = cell_addr(nb_row_r, nb_col_r);
  assign out_addr   = cell_addr(orow_r, ocol_r);
  assign sp_m1      = sp_r - SP_W'(1);
  assign sp_m2      = sp_r - SP_W'(2);
  assign sp_depth   = DW'(sp_r);

  assign stat.total_zero = (used_rows == '0) || (used_cols == '0);
  assign stat.bounds_ok  = (DIM_W'(start_row_r) < used_rows) &&
                           (DIM_W'(start_col_r) < used_cols) &&
                           (DIM_W'(goal_row_r) < used_rows) &&
                           (DIM_W'(goal_col_r) < used_cols);
  assign stat.start_goal = (start_row_r == goal_row_r) && (start_col_r == goal_col_r);
  assign stat.dir_done   = (dir_r == gmdfs_pkg::DIR_DONE);
  assign stat.sp_one     = (sp_r == SP_W'(1));
  assign stat.nb_goal    = (nb_row_r == goal_row_r) && (nb_col_r == goal_col_r);
  assign stat.out_last   = is_last;
  assign stat.out_taken  = res_valid_r && out_ready;

  // neighbour and wall cell for the current direction
  always_comb begin
    chk_edge = 1'b0;
    w_row    = cur_row_r;
    w_col    = cur_col_r;
    n_row    = cur_row_r;
    n_col    = cur_col_r;
    case (dir_r)
      gmdfs_pkg::DIR_WEST: begin
        chk_edge = (cur_col_r != '0);
        w_col    = cur_col_r - POS_W'(1);
        n_col    = cur_col_r - POS_W'(1);
      end
      gmdfs_pkg::DIR_NORTH: begin
        chk_edge = (cur_row_r != '0);
        w_row    = cur_row_r - POS_W'(1);
        n_row    = cur_row_r - POS_W'(1);
      end
      gmdfs_pkg::DIR_EAST: begin
        chk_edge = (DIM_W'(cur_col_r) + DIM_W'(1)) < used_cols;
        n_col    = cur_col_r + POS_W'(1);
      end
      gmdfs_pkg::DIR_SOUTH: begin
        chk_edge = (DIM_W'(cur_row_r) + DIM_W'(1)) < used_rows;
        n_row    = cur_row_r + POS_W'(1);
      end
      default: begin
        chk_edge = 1'b0;
      end
    endcase
  end

  // cells not yet loaded for this maze have no walls
  assign chk_loaded = (DIM_W'(w_row) < ld_row_r) ||
                      ((DIM_W'(w_row) == ld_row_r) && (w_col < ld_col_r));
  assign wall_addr  = cell_addr(w_row, w_col);

  assign wall_bit  = (dir_r == gmdfs_pkg::DIR_WEST || dir_r == gmdfs_pkg::DIR_EAST) ?
                     wall_q_r[gmdfs_pkg::WALL_EAST] : wall_q_r[gmdfs_pkg::WALL_SOUTH];
  assign stat.open = edge_ok_r && !(loaded_r && wall_bit) && !visited_r[nb_addr];

  assign push_entry.dir = dir_r[1:0];
  assign push_entry.row = cur_row_r;
  assign push_entry.col = cur_col_r;

  assign dp_we    = (cmd.init && stat.bounds_ok) || cmd.push;
  assign dp_waddr = cmd.init ? start_addr : nb_addr;
  assign dp_wdata = cmd.init ? DW'(1) : (sp_depth + DW'(1));

  assign stk_raddr = cmd.pop ? AW'(sp_m2) : AW'(depth_q_r - DW'(1));

  // a visited cell lies on the path if the stack holds it at its depth
  always_comb begin
    on_path = 1'b0;
    if (found_r && vis_q_r) begin
      if (depth_q_r == sp_depth) begin
        on_path = (cur_row_r == orow_r) && (cur_col_r == ocol_r);
      end else if (depth_q_r < sp_depth) begin
        on_path = (stk_q_r.row == orow_r) && (stk_q_r.col == ocol_r);
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r      <= gmdfs_pkg::RST_GRID_ROWS;
      cols_r      <= gmdfs_pkg::RST_GRID_COLS;
      start_row_r <= gmdfs_pkg::RST_START_ROW;
      start_col_r <= gmdfs_pkg::RST_START_COL;
      goal_row_r  <= gmdfs_pkg::RST_GOAL_ROW;
      goal_col_r  <= gmdfs_pkg::RST_GOAL_COL;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        gmdfs_pkg::CFG_GRID_ROWS: rows_r      <= cfg_wdata;
        gmdfs_pkg::CFG_GRID_COLS: cols_r      <= cfg_wdata;
        gmdfs_pkg::CFG_START_ROW: start_row_r <= cfg_wdata[POS_W-1:0];
        gmdfs_pkg::CFG_START_COL: start_col_r <= cfg_wdata[POS_W-1:0];
        gmdfs_pkg::CFG_GOAL_ROW:  goal_row_r  <= cfg_wdata[POS_W-1:0];
        gmdfs_pkg::CFG_GOAL_COL:  goal_col_r  <= cfg_wdata[POS_W-1:0];
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lc_r        <= '0;
      ld_row_r    <= '0;
      ld_col_r    <= '0;
      sp_r        <= '0;
      found_r     <= 1'b0;
      visited_r   <= '0;
      dir_r       <= gmdfs_pkg::DIR_WEST;
      orow_r      <= '0;
      ocol_r      <= '0;
      res_valid_r <= 1'b0;
    end else begin
      if (cmd.load_wall && load_ok) begin
        lc_r <= lc_r + SP_W'(1);
        if (ld_wrap) begin
          ld_col_r <= '0;
          ld_row_r <= ld_row_r + DIM_W'(1);
        end else begin
          ld_col_r <= ld_col_r + POS_W'(1);
        end
      end
      if (cmd.finish) begin
        lc_r     <= '0;
        ld_row_r <= '0;
        ld_col_r <= '0;
      end
      if (cmd.init) begin
        orow_r    <= '0;
        ocol_r    <= '0;
        dir_r     <= gmdfs_pkg::DIR_WEST;
        if (stat.bounds_ok) begin
          // only the start cell is visited
          visited_r <= CELLS'(1) << start_addr;
          sp_r      <= SP_W'(1);
          found_r   <= stat.start_goal;
        end else begin
          visited_r <= '0;
          sp_r      <= '0;
          found_r   <= 1'b0;
        end
      end
      if (cmd.pop) begin
        sp_r <= sp_m1;
      end
      if (cmd.resume) begin
        dir_r <= DIR_W'(stk_q_r.dir) + DIR_W'(1);
      end
      if (cmd.next_dir) begin
        dir_r <= dir_r + DIR_W'(1);
      end
      if (cmd.push) begin
        visited_r[nb_addr] <= 1'b1;
        sp_r               <= sp_r + SP_W'(1);
        dir_r              <= gmdfs_pkg::DIR_WEST;
        if (stat.nb_goal) begin
          found_r <= 1'b1;
        end
      end
      if (cmd.out_next) begin
        if (out_wrap) begin
          ocol_r <= '0;
          orow_r <= orow_r + POS_W'(1);
        end else begin
          ocol_r <= ocol_r + POS_W'(1);
        end
      end
      if (cmd.out_load) begin
        res_valid_r <= 1'b1;
      end else if (res_valid_r && out_ready) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  // search position and report payload
  always_ff @(posedge clk) begin
    if (cmd.init) begin
      cur_row_r <= start_row_r;
      cur_col_r <= start_col_r;
    end else if (cmd.resume) begin
      cur_row_r <= stk_q_r.row;
      cur_col_r <= stk_q_r.col;
    end else if (cmd.push) begin
      cur_row_r <= nb_row_r;
      cur_col_r <= nb_col_r;
    end
    if (cmd.check) begin
      edge_ok_r <= chk_edge;
      loaded_r  <= chk_loaded;
      nb_row_r  <= n_row;
      nb_col_r  <= n_col;
    end
    if (cmd.out_load) begin
      res_row_r   <= orow_r;
      res_col_r   <= ocol_r;
      res_vis_r   <= vis_q_r;
      res_depth_r <= vis_q_r ? depth_q_r : '0;
      res_path_r  <= on_path;
      res_last_r  <= is_last;
    end
  end

  // wall memory
  always_ff @(posedge clk) begin
    if (cmd.load_wall && load_ok) begin
      wall_mem[ld_addr] <= {south_wall, east_wall};
    end
    if (cmd.check) begin
      wall_q_r <= wall_mem[wall_addr];
    end
  end

  // depth memory
  always_ff @(posedge clk) begin
    if (dp_we) begin
      depth_mem[dp_waddr] <= dp_wdata;
    end
    if (cmd.out_rd) begin
      depth_q_r <= depth_mem[out_addr];
      vis_q_r   <= visited_r[out_addr];
    end
  end

  // stack memory, the top entry lives in the position registers
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      stack_mem[AW'(sp_m1)] <= push_entry;
    end
    if (cmd.pop || cmd.out_stk) begin
      stk_q_r <= stack_mem[stk_raddr];
    end
  end

  assign out_valid   = res_valid_r;
  assign out_row     = res_row_r;
  assign out_col     = res_col_r;
  assign out_visited = res_vis_r;
  assign out_depth   = res_depth_r;
  assign out_on_path = res_path_r;
  assign out_last    = res_last_r;

endmodule

// ----- rtl/core/grid_maze_dfs_path_finder.sv -----
// ----------------------------------------------------------------------------
// grid_maze_dfs_path_finder: depth-first search path finder on a wall grid
// Loads maze cells in raster order, searches from start to goal and reports
// depth and path marks of every cell.
// ----------------------------------------------------------------------------
// load: one cell per cycle, in_chan.ready stays high while loading.
// search: INIT sets up, then a neighbour check passes CHECK and MOVE, a backtrack
// step CHECK and POP, through the single-port wall and stack memories.
// report: OUT_RD, OUT_STK, OUT_CMP, OUT_WAIT per cell plus sink stall; ready is
// low from the last cell until the final report is taken. Reset restores the 8x8
// grid, start (0,0), goal (7,7) and clears the counters, not the memories.
module grid_maze_dfs_path_finder #(
  parameter int MAX_ROWS = gmdfs_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = gmdfs_pkg::MAX_COLS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  gmdfs_in_if.sink                         in_chan,
  gmdfs_out_if.source                      out_chan,
  input  logic                             cfg_wr_en,
  input  logic [gmdfs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gmdfs_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  gmdfs_pkg::gmdfs_cmd_t  cmd;
  gmdfs_pkg::gmdfs_stat_t stat;
  logic                   in_ready;

  assign in_chan.ready = in_ready;

  gmdfs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_last  (in_chan.last_cell),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  gmdfs_dp #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .east_wall   (in_chan.east_wall),
    .south_wall  (in_chan.south_wall),
    .out_ready   (out_chan.ready),
    .out_valid   (out_chan.valid),
    .out_row     (out_chan.cell_row),
    .out_col     (out_chan.cell_col),
    .out_visited (out_chan.visited),
    .out_depth   (out_chan.depth),
    .out_on_path (out_chan.on_path),
    .out_last    (out_chan.last_result),
    .cmd         (cmd),
    .stat        (stat)
  );

endmodule

// ----- rtl/core/gmdfs_checker.sv -----
// ----------------------------------------------------------------------------
// gmdfs_checker: port-level checks of the grid maze path finder
// Watches the load and report channels over time.
// ----------------------------------------------------------------------------
module gmdfs_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [gmdfs_pkg::POS_W-1:0]       out_row,
  input logic [gmdfs_pkg::POS_W-1:0]       out_col,
  input logic                              out_visited,
  input logic [gmdfs_pkg::DEPTH_W-1:0]     out_depth,
  input logic                              out_on_path,
  input logic                              out_last
);

  // loading and reporting never overlap
  a_no_load_while_report: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("load channel ready while a report is pending");

  // the final report of a maze reopens the load channel
  a_reload_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last) |=> in_ready)
    else $error("load channel not ready after the final report");

  // depth and path marks agree with the visit flag
  a_report_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_visited == (out_depth != '0)) && (!out_on_path || out_visited)))
    else $error("inconsistent cell report");

  // a stalled report holds
  a_report_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_row) && $stable(out_col) &&
                                   $stable(out_depth) && $stable(out_on_path) &&
                                   $stable(out_last)))
    else $error("stalled report changed");

endmodule

bind grid_maze_dfs_path_finder gmdfs_checker u_gmdfs_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_chan.ready),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .out_row     (out_chan.cell_row),
  .out_col     (out_chan.cell_col),
  .out_visited (out_chan.visited),
  .out_depth   (out_chan.depth),
  .out_on_path (out_chan.on_path),
  .out_last    (out_chan.last_result)
);

// ----- tb/sv/gmdfs_checker.sv -----
// ----------------------------------------------------------------------------
// gmdfs_scoreboard: cell report checker of the grid maze path finder
// Follows register writes and accepted cell loads, repeats the depth-first
// search on its own copy of the maze and compares every cell report with the
// oldest expected one. Hands the failure count and the number of reports
// still awaited to the testbench top.
// ----------------------------------------------------------------------------
module gmdfs_scoreboard
  import gmdfs_pkg::*;
#(
  parameter int MAX_ROWS = MAX_ROWS_DEF,
  parameter int MAX_COLS = MAX_COLS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  gmdfs_in_if                   in_chan,
  gmdfs_out_if                  out_chan,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    fail_count,
  output int                    pending_reports
);

  localparam int CELLS = MAX_ROWS * MAX_COLS;

  typedef struct packed {
    logic [POS_W-1:0]   row;
    logic [POS_W-1:0]   col;
    logic               visited;
    logic [DEPTH_W-1:0] depth;
    logic               on_path;
    logic               last;
  } cell_report_t;

  cell_report_t     report_q[$];
  logic [DIM_W-1:0] rows_reg, cols_reg;
  logic [POS_W-1:0] start_row_reg, start_col_reg, goal_row_reg, goal_col_reg;
  logic [1:0]       wall_mem [CELLS];
  int               depth_mem [CELLS];
  bit               path_mem [CELLS];
  int               trail_cell [CELLS];
  int               trail_dir [CELLS];
  int               cells_loaded;
  int               mismatches;

  always @(posedge clk) begin : scoreboard
    int           rows, cols, total, idx, start, goal, sp, cell_idx, dir, r, c, nb, k;
    bit           found, open;
    cell_report_t seen, want;
    if (!rst_n) begin
      rows_reg      = RST_GRID_ROWS;
      cols_reg      = RST_GRID_COLS;
      start_row_reg = RST_START_ROW;
      start_col_reg = RST_START_COL;
      goal_row_reg  = RST_GOAL_ROW;
      goal_col_reg  = RST_GOAL_COL;
      cells_loaded  = 0;
      mismatches    = 0;
      report_q.delete();
      for (k = 0; k < CELLS; k++) begin
        wall_mem[k] = '0;
      end
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_GRID_ROWS: rows_reg      = cfg_wdata;
          CFG_GRID_COLS: cols_reg      = cfg_wdata;
          CFG_START_ROW: start_row_reg = cfg_wdata[POS_W-1:0];
          CFG_START_COL: start_col_reg = cfg_wdata[POS_W-1:0];
          CFG_GOAL_ROW:  goal_row_reg  = cfg_wdata[POS_W-1:0];
          CFG_GOAL_COL:  goal_col_reg  = cfg_wdata[POS_W-1:0];
          default: ;
        endcase
      end

      if (out_chan.valid && out_chan.ready) begin
        seen.row     = out_chan.cell_row;
        seen.col     = out_chan.cell_col;
        seen.visited = out_chan.visited;
        seen.depth   = out_chan.depth;
        seen.on_path = out_chan.on_path;
        seen.last    = out_chan.last_result;
        if (report_q.size() == 0) begin
          if (mismatches < 10)
            $display("extra report: row %0d col %0d vis %0b depth %0d path %0b last %0b",
                     seen.row, seen.col, seen.visited, seen.depth, seen.on_path, seen.last);
          mismatches++;
        end else begin
          want = report_q.pop_front();
          if (seen !== want) begin
            if (mismatches < 10) begin
              $display("expected row %0d col %0d vis %0b depth %0d path %0b last %0b",
                       want.row, want.col, want.visited, want.depth, want.on_path,
                       want.last);
              $display("got      row %0d col %0d vis %0b depth %0d path %0b last %0b",
                       seen.row, seen.col, seen.visited, seen.depth, seen.on_path,
                       seen.last);
            end
            mismatches++;
          end
        end
      end

      if (in_chan.valid && in_chan.ready) begin
        rows  = (rows_reg > MAX_ROWS) ? MAX_ROWS : int'(rows_reg);
        cols  = (cols_reg > MAX_COLS) ? MAX_COLS : int'(cols_reg);
        total = rows * cols;
        if (cells_loaded < total) begin
          idx = (cells_loaded / cols) * MAX_COLS + cells_loaded % cols;
          wall_mem[idx][WALL_EAST]  = in_chan.east_wall;
          wall_mem[idx][WALL_SOUTH] = in_chan.south_wall;
          cells_loaded++;
        end

        if (in_chan.last_cell) begin
          for (k = 0; k < CELLS; k++) begin
            depth_mem[k] = 0;
            path_mem[k]  = 1'b0;
          end
          found = 1'b0;
          sp    = 0;
          if (start_row_reg < rows && start_col_reg < cols &&
              goal_row_reg < rows && goal_col_reg < cols) begin
            start = start_row_reg * MAX_COLS + start_col_reg;
            goal  = goal_row_reg * MAX_COLS + goal_col_reg;
            depth_mem[start] = 1;
            trail_cell[0]    = start;
            trail_dir[0]     = DIR_WEST;
            sp    = 1;
            found = (start == goal);
            while (!found && sp > 0) begin
              cell_idx = trail_cell[sp-1];
              dir      = trail_dir[sp-1];
              r        = cell_idx / MAX_COLS;
              c        = cell_idx % MAX_COLS;
              if (dir >= DIR_DONE) begin
                sp--;
              end else begin
                trail_dir[sp-1] = dir + 1;
                case (dir)
                  DIR_WEST: begin
                    open = (c > 0) && !wall_mem[cell_idx-1][WALL_EAST];
                    nb   = cell_idx - 1;
                  end
                  DIR_NORTH: begin
                    open = (r > 0) && !wall_mem[cell_idx-MAX_COLS][WALL_SOUTH];
                    nb   = cell_idx - MAX_COLS;
                  end
                  DIR_EAST: begin
                    open = (c + 1 < cols) && !wall_mem[cell_idx][WALL_EAST];
                    nb   = cell_idx + 1;
                  end
                  default: begin
                    open = (r + 1 < rows) && !wall_mem[cell_idx][WALL_SOUTH];
                    nb   = cell_idx + MAX_COLS;
                  end
                endcase
                if (open && depth_mem[nb] == 0 && sp < CELLS) begin
                  depth_mem[nb]  = sp + 1;
                  trail_cell[sp] = nb;
                  trail_dir[sp]  = DIR_WEST;
                  sp++;
                  found = (nb == goal);
                end
              end
            end
            // whatever is left on the stack is the start-to-goal chain
            if (found) begin
              for (k = 0; k < sp; k++) begin
                path_mem[trail_cell[k]] = 1'b1;
              end
            end
          end

          for (r = 0; r < rows; r++) begin
            for (c = 0; c < cols; c++) begin
              cell_idx     = r * MAX_COLS + c;
              want.row     = POS_W'(r);
              want.col     = POS_W'(c);
              want.visited = (depth_mem[cell_idx] != 0);
              want.depth   = DEPTH_W'(depth_mem[cell_idx]);
              want.on_path = path_mem[cell_idx];
              want.last    = (r * cols + c + 1 == total);
              report_q.push_back(want);
            end
          end
          cells_loaded = 0;
          for (k = 0; k < CELLS; k++) begin
            wall_mem[k] = '0;
          end
        end
      end
    end
    fail_count      <= mismatches;
    pending_reports <= report_q.size();
  end

endmodule

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: top of the grid maze path finder test
// Loads whole mazes cell by cell under several grid sizes, start and goal
// settings and wall densities, with random gaps on both channels. The checker
// beside the block predicts every cell report; the top gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
  import gmdfs_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE       = 100;  // search and report tail of one maze
  localparam int RANDOM_ITEMS = 270;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    fail_count;
  int                    pending_reports;
  int                    send_idle_pct = 34;
  int                    recv_idle_pct = 74;
  int                    cycle_count = 0;
  int                    cells_sent = 0;

  gmdfs_in_if  in_chan ();
  gmdfs_out_if out_chan ();

  grid_maze_dfs_path_finder DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  gmdfs_scoreboard u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_chan         (in_chan),
    .out_chan        (out_chan),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .fail_count      (fail_count),
    .pending_reports (pending_reports)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // all reports in and the block back at rest
  task automatic wait_idle();
    do @(negedge clk); while (pending_reports != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic configure(input int rows, input int cols, input int srow, input int scol,
                           input int grow, input int gcol);
    wait_idle();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_GRID_ROWS;
    cfg_wdata <= CFG_DATA_W'(rows);
    @(negedge clk);
    cfg_index <= CFG_GRID_COLS;
    cfg_wdata <= CFG_DATA_W'(cols);
    // the top bit of a position write is junk and must be dropped
    @(negedge clk);
    cfg_index <= CFG_START_ROW;
    cfg_wdata <= {1'($urandom_range(1)), POS_W'(srow)};
    @(negedge clk);
    cfg_index <= CFG_START_COL;
    cfg_wdata <= {1'($urandom_range(1)), POS_W'(scol)};
    @(negedge clk);
    cfg_index <= CFG_GOAL_ROW;
    cfg_wdata <= {1'($urandom_range(1)), POS_W'(grow)};
    @(negedge clk);
    cfg_index <= CFG_GOAL_COL;
    cfg_wdata <= {1'($urandom_range(1)), POS_W'(gcol)};
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic send_cell(input logic east, input logic south, input logic last);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.east_wall  <= east;
    in_chan.south_wall <= south;
    in_chan.last_cell  <= last;
    do @(posedge clk); while (!in_chan.ready);
    cells_sent++;
  endtask

  // loads every cell of the grid plus surplus ones, last flag on the final one
  task automatic run_maze(input int rows, input int cols, input int wall_pct,
                          input bit serpentine, input int surplus);
    int  ur, uc, total, n, r, c;
    bit  east, south;
    ur    = (rows > MAX_ROWS_DEF) ? MAX_ROWS_DEF : rows;
    uc    = (cols > MAX_COLS_DEF) ? MAX_COLS_DEF : cols;
    total = ur * uc;
    for (n = 0; n < total + surplus || n == 0; n++) begin
      r = (uc > 0) ? n / uc : 0;
      c = (uc > 0) ? n % uc : 0;
      if (serpentine) begin
        // one long corridor snaking down the rows
        east  = 1'b0;
        south = !((r % 2 == 0 && c == uc - 1) || (r % 2 == 1 && c == 0));
      end else begin
        east  = ($urandom_range(99) < wall_pct);
        south = ($urandom_range(99) < wall_pct);
      end
      send_cell(east, south, (n + 1 >= total + surplus));
    end
    @(negedge clk);
    in_chan.valid <= 1'b0;
  endtask

  initial begin
    int random_base, phase, sel, rows, cols, ur, uc, srow, scol, grow, gcol;
    rst_n              = 1'b0;
    cfg_wr_en          = 1'b0;
    cfg_index          = CFG_GRID_ROWS;
    cfg_wdata          = '0;
    in_chan.valid      = 1'b0;
    in_chan.east_wall  = 1'b0;
    in_chan.south_wall = 1'b0;
    in_chan.last_cell  = 1'b0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // single cell, start on goal
    configure(1, 1, 0, 0, 0, 0);
    run_maze(1, 1, 0, 0, 0);
    // empty grids
    configure(0, 3, 0, 0, 0, 0);
    run_maze(0, 3, 50, 0, 0);
    configure(3, 0, 0, 0, 0, 0);
    run_maze(3, 0, 50, 0, 0);
    // open 2x2
    configure(2, 2, 0, 0, 1, 1);
    run_maze(2, 2, 0, 0, 0);
    // start outside the grid
    configure(2, 2, 2, 0, 1, 1);
    run_maze(2, 2, 100, 0, 0);
    // walled in, goal unreachable
    configure(2, 3, 1, 1, 0, 0);
    run_maze(2, 3, 100, 0, 0);
    // oversized column count, goal behind the start, surplus cell
    configure(1, 15, 0, 7, 0, 0);
    run_maze(1, 15, 0, 0, 1);

    random_base = cells_sent;
    // deepest search: every cell on one path
    configure(8, 8, 0, 0, 7, 0);
    run_maze(8, 8, 0, 1, 0);

    while (cells_sent - random_base < RANDOM_ITEMS) begin
      phase = (cells_sent - random_base) * 3 / RANDOM_ITEMS;
      sel   = $urandom_range(99);
      if (sel < 4) begin
        rows = $urandom_range(1) ? 0 : $urandom_range(1, 15);
        cols = (rows == 0) ? $urandom_range(15) : 0;
      end else if (sel < 80) begin
        rows = $urandom_range(1, 4);
        cols = $urandom_range(1, 4);
      end else if (sel < 94) begin
        rows = $urandom_range(1, 8);
        cols = $urandom_range(1, 8);
      end else begin
        rows = $urandom_range(9, 15);
        cols = $urandom_range(9, 15);
      end
      ur = (rows > MAX_ROWS_DEF) ? MAX_ROWS_DEF : rows;
      uc = (cols > MAX_COLS_DEF) ? MAX_COLS_DEF : cols;
      if (ur > 0 && uc > 0 && $urandom_range(99) < 85) begin
        srow = $urandom_range(ur - 1);
        scol = $urandom_range(uc - 1);
        grow = $urandom_range(ur - 1);
        gcol = $urandom_range(uc - 1);
      end else begin
        srow = $urandom_range(7);
        scol = $urandom_range(7);
        grow = $urandom_range(7);
        gcol = $urandom_range(7);
      end
      configure(rows, cols, srow, scol, grow, gcol);
      @(posedge clk);
      if (phase == 0) begin
        send_idle_pct = 34;
        recv_idle_pct = 74;
      end else if (phase == 1) begin
        send_idle_pct = 74;
        recv_idle_pct = 34;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      run_maze(rows, cols, $urandom_range(60), 0,
               ($urandom_range(99) < 20) ? $urandom_range(1, 3) : 0);
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/gmdfs_pkg.sv
rtl/core/gmdfs_if.sv
rtl/core/gmdfs_ctrl.sv
rtl/core/gmdfs_dp.sv
rtl/core/grid_maze_dfs_path_finder.sv
rtl/core/gmdfs_checker.sv
tb/sv/gmdfs_checker.sv
tb/sv/testbench.sv
